[design/calendar_date_register_core_defines.svh]
// Assertion macros for the calendar date register core.
// Included by the top level; relies on clk and rst_n being in scope.
`ifndef CALENDAR_DATE_REGISTER_CORE_DEFINES_SVH
`define CALENDAR_DATE_REGISTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CDR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cdr_pkg.sv]
// Shared types, constants and calendar helpers for the date register core.
// No dependencies; used by the interfaces and the top level.
package cdr_pkg;

  localparam int KIND_W     = 2;
  localparam int DAY_W      = 5;
  localparam int NEW_DAY_W  = 6;
  localparam int MONTH_W    = 4;
  localparam int YEAR_W     = 12;
  localparam int COUNT_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET        = 2'd0,
    KIND_ADD_DAYS   = 2'd1,
    KIND_ADD_MONTHS = 2'd2,
    KIND_ADD_YEARS  = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_MONTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_YEAR  = 2'd2;

  localparam logic [DAY_W-1:0]   RST_DAY    = 5'd7;
  localparam logic [MONTH_W-1:0] RST_MONTH  = 4'd8;
  localparam logic [YEAR_W-1:0]  RST_YEAR   = 12'd1986;
  localparam logic [YEAR_W-1:0]  YEAR_CEIL  = 12'd4095;
  localparam logic [MONTH_W-1:0] JAN        = 4'd1;
  localparam logic [MONTH_W-1:0] FEB        = 4'd2;
  localparam logic [MONTH_W-1:0] MAR        = 4'd3;
  localparam logic [MONTH_W-1:0] DEC        = 4'd12;
  localparam logic [DAY_W-1:0]   FIRST_DAY  = 5'd1;
  localparam logic [DAY_W-1:0]   LEAP_DAY   = 5'd29;

  // y / 100 as (y * 5243) >> 19, exact for 12-bit y
  localparam logic [12:0] DIV100_MUL   = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] d;
    case (m)
      4'd2:                      d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;  // 31-day months and out-of-range codes
    endcase
    return d;
  endfunction

  function automatic logic [5:0] div100(input logic [YEAR_W-1:0] y);
    logic [24:0] p;
    p = {13'd0, y} * {12'd0, DIV100_MUL};
    return p[DIV100_SHIFT+5:DIV100_SHIFT];
  endfunction

  // q is y / 100; century years are leap only when q is a multiple of 4
  function automatic logic leap_from(input logic [YEAR_W-1:0] y, input logic [5:0] q);
    logic [YEAR_W-1:0] hund;
    hund = {q, 6'd0} + {1'b0, q, 5'd0} + {4'd0, q, 2'd0};
    return (y[1:0] == 2'd0) && ((y != hund) || (q[1:0] == 2'd0));
  endfunction

endpackage

[design/cdr_if.sv]
// Item channels of the date register core: operation request and date result.
// Depends on cdr_pkg for field widths.
interface cdr_in_if;
  import cdr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    kind;
  logic [NEW_DAY_W-1:0] new_day;
  logic [MONTH_W-1:0]   new_month;
  logic [YEAR_W-1:0]    new_year;
  logic [COUNT_W-1:0]   step_count;
  modport source (output valid, kind, new_day, new_month, new_year, step_count,
                  input ready);
  modport sink   (input valid, kind, new_day, new_month, new_year, step_count,
                  output ready);
endinterface

interface cdr_out_if;
  import cdr_pkg::*;
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   cur_day;
  logic [MONTH_W-1:0] cur_month;
  logic [YEAR_W-1:0]  cur_year;
  logic               day_rejected;
  modport source (output valid, cur_day, cur_month, cur_year, day_rejected,
                  input ready);
  modport sink   (input valid, cur_day, cur_month, cur_year, day_rejected,
                  output ready);
endinterface

[design/calendar_date_register_core.sv]
// Gregorian date register: set, add days, add months, add years, one result per item.
// Set and add-years pass the load or year-add state, the leap wait and a day check
// or fix-up; add-days/add-months step one day or month per cycle through the shared step unit.
// Next item is taken the cycle after the result is loaded; a full output register
// stalls only the final load. Sync active-low reset: date 7/8/1986, same defaults.
// Depends on cdr_pkg, cdr_if and calendar_date_register_core_defines.svh.
module calendar_date_register_core #(
  parameter int COUNT_BITS     = 12,
  parameter int MAX_VALID_YEAR = 3000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cdr_in_if.sink                         in_ch,
  cdr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [cdr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cdr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cdr_pkg::*;
  `include "calendar_date_register_core_defines.svh"

  // only the low COUNT_BITS of the 12-bit count matter
  localparam int CNT_W = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
  localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(MAX_VALID_YEAR);
  // countdown loaded into wait_r so that leap_r reflects a year write before it is read
  localparam logic [1:0] LEAP_WAIT = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_LOAD,   // validated year and month written
    ST_LEAP_WAIT,  // leap pipeline catching up with year_r
    ST_SET_DAY,    // day checked against new month/year
    ST_DAYS,       // one day per cycle
    ST_MONTHS,     // one month per cycle
    ST_YEARS_ADD,  // saturating year add
    ST_YEARS_FIX,  // 29 Feb -> 1 Mar when the new year is not leap
    ST_DONE        // hand result to the output register
  } state_t;

  state_t               state_r, state_nxt;
  kind_t                kind_r, kind_nxt;
  logic [DAY_W-1:0]     day_r, day_nxt;
  logic [MONTH_W-1:0]   month_r, month_nxt;
  logic [YEAR_W-1:0]    year_r, year_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NEW_DAY_W-1:0] nd_r, nd_nxt;
  logic [MONTH_W-1:0]   nm_r, nm_nxt;
  logic [YEAR_W-1:0]    ny_r, ny_nxt;
  logic                 rej_r, rej_nxt;
  logic [1:0]           wait_r, wait_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [DAY_W-1:0]     out_day_r, out_day_nxt;
  logic [MONTH_W-1:0]   out_month_r, out_month_nxt;
  logic [YEAR_W-1:0]    out_year_r, out_year_nxt;
  logic                 out_rej_r, out_rej_nxt;

  logic [DAY_W-1:0]     dflt_day_r;
  logic [MONTH_W-1:0]   dflt_month_r;
  logic [YEAR_W-1:0]    dflt_year_r;

  // leap flag pipeline: quotient stage, then compare stage
  logic [YEAR_W-1:0]    y1_r;
  logic [5:0]           q_r;
  logic                 leap_r;

  logic                 in_fire;
  logic [5:0]           d_inc;
  logic [4:0]           m_inc;
  logic [YEAR_W-1:0]    y_inc;
  logic [YEAR_W:0]      y_sum;
  logic                 month_wrap;
  logic                 out_free;

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign in_fire             = in_ch.valid && (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.cur_day      = out_day_r;
  assign out_ch.cur_month    = out_month_r;
  assign out_ch.cur_year     = out_year_r;
  assign out_ch.day_rejected = out_rej_r;
  assign out_free            = !out_valid_r || out_ch.ready;

  // shared step unit
  assign d_inc      = {1'b0, day_r} + 6'd1;
  assign m_inc      = {1'b0, month_r} + 5'd1;
  assign month_wrap = (m_inc > {1'b0, DEC});
  assign y_inc      = (year_r == YEAR_CEIL) ? year_r : year_r + 12'd1;
  assign y_sum      = {1'b0, year_r} + (YEAR_W+1)'(cnt_r);

  always_ff @(posedge clk) begin
    y1_r   <= year_r;
    q_r    <= div100(year_r);
    leap_r <= leap_from(y1_r, q_r);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_day_r   <= RST_DAY;
      dflt_month_r <= RST_MONTH;
      dflt_year_r  <= RST_YEAR;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEFAULT_DAY:   dflt_day_r   <= cfg_wdata[DAY_W-1:0];
        CFG_DEFAULT_MONTH: dflt_month_r <= cfg_wdata[MONTH_W-1:0];
        CFG_DEFAULT_YEAR:  dflt_year_r  <= cfg_wdata[YEAR_W-1:0];
        default: ;  // no register at this index
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    cnt_nxt       = cnt_r;
    nd_nxt        = nd_r;
    nm_nxt        = nm_r;
    ny_nxt        = ny_r;
    rej_nxt       = rej_r;
    wait_nxt      = wait_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_day_nxt   = out_day_r;
    out_month_nxt = out_month_r;
    out_year_nxt  = out_year_r;
    out_rej_nxt   = out_rej_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          kind_nxt = kind_t'(in_ch.kind);
          nd_nxt   = in_ch.new_day;
          nm_nxt   = in_ch.new_month;
          ny_nxt   = in_ch.new_year;
          cnt_nxt  = in_ch.step_count[CNT_W-1:0];
          rej_nxt  = 1'b0;
          unique case (kind_t'(in_ch.kind))
            KIND_SET:        state_nxt = ST_SET_LOAD;
            KIND_ADD_DAYS:   state_nxt = ST_DAYS;
            KIND_ADD_MONTHS: state_nxt = ST_MONTHS;
            KIND_ADD_YEARS:  state_nxt = ST_YEARS_ADD;
            default:         state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_SET_LOAD: begin
        year_nxt  = (ny_r != '0 && ny_r <= MAX_YEAR) ? ny_r : dflt_year_r;
        month_nxt = (nm_r != '0 && nm_r <= DEC) ? nm_r : dflt_month_r;
        wait_nxt  = LEAP_WAIT;
        state_nxt = ST_LEAP_WAIT;
      end

      ST_LEAP_WAIT: begin
        if (wait_r != 2'd0) begin
          wait_nxt = wait_r - 2'd1;
        end else if (kind_r == KIND_SET) begin
          state_nxt = ST_SET_DAY;
        end else begin
          state_nxt = ST_YEARS_FIX;
        end
      end

      ST_SET_DAY: begin
        if ((nd_r != '0 && nd_r <= {1'b0, days_in(month_r)}) ||
            (month_r == FEB && nd_r == {1'b0, LEAP_DAY} && leap_r)) begin
          day_nxt = nd_r[DAY_W-1:0];
        end else begin
          day_nxt = dflt_day_r;
          rej_nxt = 1'b1;
        end
        state_nxt = ST_DONE;
      end

      ST_DAYS: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          if (month_r == FEB && d_inc == {1'b0, LEAP_DAY} && leap_r) begin
            day_nxt = d_inc[DAY_W-1:0];
          end else if (d_inc > {1'b0, days_in(month_r)}) begin
            // month carry; a year carry lands on 1 Jan so no leap fix-up
            day_nxt = FIRST_DAY;
            if (month_wrap) begin
              month_nxt = JAN;
              year_nxt  = y_inc;
            end else begin
              month_nxt = m_inc[MONTH_W-1:0];
            end
          end else begin
            day_nxt = d_inc[DAY_W-1:0];
          end
        end
      end

      ST_MONTHS: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          if (month_wrap) begin
            month_nxt = JAN;
            year_nxt  = y_inc;
          end else begin
            month_nxt = m_inc[MONTH_W-1:0];
          end
        end
      end

      ST_YEARS_ADD: begin
        year_nxt  = (y_sum > {1'b0, YEAR_CEIL}) ? YEAR_CEIL : y_sum[YEAR_W-1:0];
        wait_nxt  = LEAP_WAIT;
        state_nxt = ST_LEAP_WAIT;
      end

      ST_YEARS_FIX: begin
        if (day_r == LEAP_DAY && month_r == FEB && !leap_r) begin
          day_nxt   = FIRST_DAY;
          month_nxt = MAR;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_day_nxt   = day_r;
          out_month_nxt = month_r;
          out_year_nxt  = year_r;
          out_rej_nxt   = rej_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      day_r       <= RST_DAY;
      month_r     <= RST_MONTH;
      year_r      <= RST_YEAR;
      wait_r      <= 2'd0;
      rej_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      wait_r      <= wait_nxt;
      rej_r       <= rej_nxt;
    end
    kind_r      <= kind_nxt;
    cnt_r       <= cnt_nxt;
    nd_r        <= nd_nxt;
    nm_r        <= nm_nxt;
    ny_r        <= ny_nxt;
    out_day_r   <= out_day_nxt;
    out_month_r <= out_month_nxt;
    out_year_r  <= out_year_nxt;
    out_rej_r   <= out_rej_nxt;
  end

  // an accepted item always leaves idle
  `CDR_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r != ST_IDLE, "accept stayed idle")
  // step loops count down by one per step
  `CDR_ASSERT_NEXT(a_step_count_down,
                   (state_r == ST_DAYS || state_r == ST_MONTHS) && cnt_r != '0,
                   cnt_r == $past(cnt_r) - 1'b1, "step counter did not decrement")
  // day and month stepping never moves the year backwards
  `CDR_ASSERT_NEXT(a_year_monotonic, state_r == ST_DAYS || state_r == ST_MONTHS,
                   year_r >= $past(year_r), "year decreased while stepping")
  // a new result only appears out of the done state
  `CDR_ASSERT_SAME(a_result_from_done, $rose(out_valid_r),
                   $past(state_r) == ST_DONE, "result loaded outside done")

endmodule

[tb/sv/tb.sv]
// Testbench for calendar_date_register_core: directed and random set/add operations,
// each result checked field by field against an in-bench calendar predictor.
// Depends on cdr_pkg, the cdr_in_if/cdr_out_if channels and the core itself.
module tb;
  import cdr_pkg::*;

  localparam int COUNT_BITS     = 12;
  localparam int MAX_VALID_YEAR = 3000;

  // Slowest legal run is roughly 140 items, each a longest-count step walk plus gaps,
  // plus one long hold-off; the limit sits a few times above that.
  localparam int unsigned LIMIT_CYCLES  = 3_000_000;
  localparam int unsigned LONG_HOLD     = 400;  // receiver hold-off, in cycles
  localparam int unsigned SETTLE_CYCLES = 8;    // extra idle wait after the last result drains
  localparam int unsigned PHASE_ITEMS   = 28;
  localparam int unsigned MAX_GAP       = 13;

  // Only the index the core does not decode.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MASK =
    (COUNT_BITS >= COUNT_W) ? '1 : COUNT_W'((1 << COUNT_BITS) - 1);

  // Years around the leap-rule corners: century, 400-year, plain leap, limits.
  localparam int unsigned PROBE_YEARS [12] =
    '{1, 4, 100, 1600, 1700, 1900, 2000, 2023, 2024, 2100, 2400, 3000};

  typedef struct packed {
    kind_t                kind;
    logic [NEW_DAY_W-1:0] new_day;
    logic [MONTH_W-1:0]   new_month;
    logic [YEAR_W-1:0]    new_year;
    logic [COUNT_W-1:0]   step_count;
  } date_op_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               rejected;
  } date_t;

  // Mirrors the date registers and the defaults; queues the date each
  // accepted item should produce and checks results against them in order.
  class calendar_mirror;
    logic [DAY_W-1:0]   dflt_day;
    logic [MONTH_W-1:0] dflt_month;
    logic [YEAR_W-1:0]  dflt_year;
    int unsigned        day, month, year;
    date_t              expected_dates[$];
    int unsigned        n_errors;

    function new();
      dflt_day   = RST_DAY;
      dflt_month = RST_MONTH;
      dflt_year  = RST_YEAR;
      day        = RST_DAY;
      month      = RST_MONTH;
      year       = RST_YEAR;
      n_errors   = 0;
    endfunction

    function void set_default(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DEFAULT_DAY:   dflt_day   = val[DAY_W-1:0];
        CFG_DEFAULT_MONTH: dflt_month = val[MONTH_W-1:0];
        CFG_DEFAULT_YEAR:  dflt_year  = val[YEAR_W-1:0];
        default: ;
      endcase
    endfunction

    function bit leap(int unsigned y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    // Codes outside 1..12 behave as 31-day months
    function int unsigned month_days(int unsigned m);
      int unsigned len [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (m >= 1 && m <= 12) return len[m];
      return 31;
    endfunction

    function void bump_year(int unsigned n);
      year = year + n;
      if (year > YEAR_CEIL) year = YEAR_CEIL;
      if (day == LEAP_DAY && month == FEB && !leap(year)) begin
        day   = FIRST_DAY;
        month = MAR;
      end
    endfunction

    function void next_month();
      month++;
      if (month > DEC) begin
        month = JAN;
        bump_year(1);
      end
    endfunction

    function void next_day();
      day++;
      if (month == FEB && day == LEAP_DAY && leap(year)) return;
      if (day > month_days(month)) begin
        day = FIRST_DAY;
        next_month();
      end
    endfunction

    function void note_op(date_op_t op);
      int unsigned cnt;
      date_t       e;
      cnt        = op.step_count & COUNT_MASK;
      e.rejected = 1'b0;
      case (op.kind)
        KIND_SET: begin
          year  = (op.new_year >= 1 && op.new_year <= MAX_VALID_YEAR) ?
                  op.new_year : dflt_year;
          month = (op.new_month >= 1 && op.new_month <= 12) ? op.new_month : dflt_month;
          if (op.new_day >= 1 && op.new_day <= month_days(month))
            day = op.new_day;
          else if (month == FEB && op.new_day == LEAP_DAY && leap(year))
            day = op.new_day;
          else begin
            day        = dflt_day;
            e.rejected = 1'b1;
          end
        end
        KIND_ADD_DAYS:   repeat (cnt) next_day();
        KIND_ADD_MONTHS: repeat (cnt) next_month();
        default:         bump_year(cnt);
      endcase
      day   = DAY_W'(day);
      month = MONTH_W'(month);
      year  = YEAR_W'(year);
      e.day   = DAY_W'(day);
      e.month = MONTH_W'(month);
      e.year  = YEAR_W'(year);
      expected_dates.push_back(e);
    endfunction

    task report(string msg);
      $display("[tb] %0t mismatch: %s", $time, msg);
      n_errors++;
    endtask

    task check_date(date_t got);
      date_t want;
      if (expected_dates.size() == 0) begin
        report($sformatf("unexpected result %0d/%0d/%0d", got.day, got.month, got.year));
        return;
      end
      want = expected_dates.pop_front();
      if (got.day !== want.day)
        report($sformatf("cur_day %0d, expected %0d", got.day, want.day));
      if (got.month !== want.month)
        report($sformatf("cur_month %0d, expected %0d", got.month, want.month));
      if (got.year !== want.year)
        report($sformatf("cur_year %0d, expected %0d", got.year, want.year));
      if (got.rejected !== want.rejected)
        report($sformatf("day_rejected %0b, expected %0b", got.rejected, want.rejected));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  cdr_in_if  in_ch();
  cdr_out_if out_ch();

  calendar_mirror mirror = new();

  bit          quiet_mode;     // both sides stop idling while set
  bit          hold_off_req;   // asks the receiver for one long stall
  int unsigned cycle_count;

  calendar_date_register_core #(
    .COUNT_BITS     (COUNT_BITS),
    .MAX_VALID_YEAR (MAX_VALID_YEAR)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hang guard: counts every clock from time zero.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: FAIL");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return quiet_mode ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  // valid stays high on return so back-to-back items never drop it.
  task automatic send_op(input kind_t k, input int unsigned d, m, y, n);
    date_op_t    op;
    int unsigned gap;
    op.kind       = k;
    op.new_day    = NEW_DAY_W'(d);
    op.new_month  = MONTH_W'(m);
    op.new_year   = YEAR_W'(y);
    op.step_count = COUNT_W'(n);
    gap = draw_gap();
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.kind       = op.kind;
    in_ch.new_day    = op.new_day;
    in_ch.new_month  = op.new_month;
    in_ch.new_year   = op.new_year;
    in_ch.step_count = op.step_count;
    do @(posedge clk); while (!in_ch.ready);
    mirror.note_op(op);
    @(negedge clk);
  endtask

  task automatic send_random_op();
    int unsigned pick, d, m, y, n;
    kind_t       k;
    pick = $urandom_range(0, 99);
    if (pick < 25)      k = KIND_SET;
    else if (pick < 55) k = KIND_ADD_DAYS;
    else if (pick < 75) k = KIND_ADD_MONTHS;
    else                k = KIND_ADD_YEARS;
    // Full-range fields: unused on add items, out-of-range probes on set items
    d = $urandom_range(0, 63);
    m = $urandom_range(0, 15);
    y = $urandom_range(0, 4095);
    if (k == KIND_SET && $urandom_range(0, 5) != 0) begin
      // mostly plausible dates, with end of February favored
      y = ($urandom_range(0, 2) == 0) ? PROBE_YEARS[$urandom_range(0, 11)]
                                      : $urandom_range(1, MAX_VALID_YEAR);
      m = $urandom_range(1, 12);
      d = $urandom_range(1, 31);
      if ($urandom_range(0, 3) == 0) begin
        m = FEB;
        d = $urandom_range(27, 30);
      end
    end
    // Step counts: mostly short walks, a few long ones to bound run time
    n = $urandom_range(1, 40);
    case ($urandom_range(0, 15))
      0:       n = 0;
      1:       n = $urandom_range(0, 4095);
      2, 3, 4: n = $urandom_range(0, 400);
      default: ;
    endcase
    send_op(k, d, m, y, n);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = CFG_DATA_W'(val);
    mirror.set_default(idx, CFG_DATA_W'(val));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop valid and let every outstanding result drain before touching config.
  task automatic settle();
    in_ch.valid = 1'b0;
    while (mirror.expected_dates.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result side: random stall per item, one long stall on request.
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draw_gap();
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap          = LONG_HOLD;
      end
      if (gap != 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      mirror.check_date({out_ch.cur_day, out_ch.cur_month, out_ch.cur_year,
                         out_ch.day_rejected});
  end

  initial begin : stimulus
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_SET;
    in_ch.new_day    = '0;
    in_ch.new_month  = '0;
    in_ch.new_year   = '0;
    in_ch.step_count = '0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_DEFAULT_DAY;
    cfg_wdata        = '0;
    quiet_mode       = 1'b0;
    hold_off_req     = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults 7/8/1986
    send_op(KIND_ADD_DAYS, 0, 0, 0, 0);           // zero step: date unchanged
    send_op(KIND_SET, 29, 2, 2000, 0);            // 400-year leap day accepted
    send_op(KIND_ADD_YEARS, 0, 0, 0, 1);          // leap day into 2001 -> 1 March
    send_op(KIND_SET, 29, 2, 1900, 0);            // century non-leap: day rejected
    send_op(KIND_SET, 31, 12, MAX_VALID_YEAR, 0); // top valid year
    send_op(KIND_ADD_DAYS, 0, 0, 0, 1);           // carry into next year
    send_op(KIND_SET, 0, 0, 0, 0);                // every field invalid, low end
    send_op(KIND_SET, 63, 15, 4095, 0);           // every field invalid, high end
    send_op(KIND_SET, 28, 2, 2024, 0);
    send_op(KIND_ADD_DAYS, 0, 0, 0, 1);           // 29 Feb in a leap year
    send_op(KIND_ADD_DAYS, 0, 0, 0, 1);
    send_op(KIND_SET, 31, 1, 2023, 0);
    send_op(KIND_ADD_MONTHS, 0, 0, 0, 1);         // 31 Feb, day not rechecked
    send_op(KIND_ADD_DAYS, 0, 0, 0, 1);           // day past month end carries
    send_op(KIND_ADD_MONTHS, 63, 15, 4095, 4095); // longest month walk
    send_op(KIND_SET, 30, 12, MAX_VALID_YEAR, 0);
    send_op(KIND_ADD_YEARS, 0, 0, 0, 4095);       // year saturates
    send_op(KIND_ADD_DAYS, 0, 0, 0, 4095);        // longest day walk at the ceiling
    send_op(KIND_SET, 1, 1, 1, 0);
    send_op(KIND_ADD_MONTHS, 0, 0, 0, 12);

    // Defaults that are themselves invalid: 31 February
    settle();
    write_reg(CFG_DEFAULT_DAY, 31);
    write_reg(CFG_DEFAULT_MONTH, FEB);
    write_reg(CFG_DEFAULT_YEAR, 2001);
    send_op(KIND_SET, 40, 13, 0, 0);
    send_op(KIND_ADD_DAYS, 0, 0, 0, 1);

    // All-zero defaults: month code 0 acts as a 31-day month; unused index ignored
    settle();
    write_reg(CFG_DEFAULT_DAY, 0);
    write_reg(CFG_DEFAULT_MONTH, 0);
    write_reg(CFG_DEFAULT_YEAR, 0);
    write_reg(CFG_UNUSED_IDX, 4095);
    send_op(KIND_SET, 0, 0, 0, 0);
    send_op(KIND_ADD_DAYS, 0, 0, 0, 32);
    send_op(KIND_ADD_YEARS, 0, 0, 0, 1);

    // Top defaults: month 15 wraps to January and bumps a saturated year
    settle();
    write_reg(CFG_DEFAULT_DAY, 31);
    write_reg(CFG_DEFAULT_MONTH, 15);
    write_reg(CFG_DEFAULT_YEAR, 4095);
    send_op(KIND_SET, 0, 0, 0, 0);
    send_op(KIND_ADD_MONTHS, 0, 0, 0, 1);

    // Random phases, each under its own defaults
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(CFG_DEFAULT_DAY, $urandom_range(1, 31));
          write_reg(CFG_DEFAULT_MONTH, $urandom_range(1, 12));
          write_reg(CFG_DEFAULT_YEAR, $urandom_range(1, MAX_VALID_YEAR));
          hold_off_req = 1'b1;  // output backs up while items keep coming
        end
        1: begin
          write_reg(CFG_DEFAULT_DAY, 1);
          write_reg(CFG_DEFAULT_MONTH, DEC);
          write_reg(CFG_DEFAULT_YEAR, MAX_VALID_YEAR);
          quiet_mode = 1'b1;    // back-to-back on both sides
        end
        2: begin
          quiet_mode = 1'b0;
          // full-width data: only the low bits of each register are kept
          write_reg(CFG_DEFAULT_DAY, $urandom_range(0, 4095));
          write_reg(CFG_DEFAULT_MONTH, $urandom_range(0, 4095));
          write_reg(CFG_DEFAULT_YEAR, $urandom_range(0, 4095));
          write_reg(CFG_UNUSED_IDX, $urandom_range(0, 4095));
        end
        default: begin
          write_reg(CFG_DEFAULT_DAY, 31);
          write_reg(CFG_DEFAULT_MONTH, JAN);
          write_reg(CFG_DEFAULT_YEAR, 1);
        end
      endcase
      repeat (PHASE_ITEMS) send_random_op();
    end

    settle();
    if (mirror.n_errors == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
